// ===== design/bsc_pkg.sv =====
`default_nettype none
package bsc_pkg;

  // field widths
  localparam int RAW_T_W  = 16;
  localparam int RAW_P_W  = 24;
  localparam int TIN_W    = 16;
  localparam int VALUE_W  = 21;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 64;
  localparam int CFG_IDX_W = 2;

  // datapath widths
  localparam int MAGA_W = 57;
  localparam int MAGD_W = 58;
  localparam int NLIN_W = 34;
  localparam int DVD_W  = 104;
  localparam int QUO_W  = 63;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CAL_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_B = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_C = 2'd2;

  // opcodes
  localparam logic OP_TEMP = 1'b0;
  localparam logic OP_PRES = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SAT  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO = 2'd2;

  // arithmetic constants
  localparam int T_REF      = 6400;      // 25 degC in 1/256 units
  localparam int TEMP_DIV   = 20480;
  localparam int TEMP_HALF  = 10240;
  localparam int RECIP5     = 52429;     // ceil(2^18 / 5), exact below 2^18
  localparam int P_BIAS     = 39667630;  // rnd(3783 * 2^18 / 25)
  localparam int K_ZQ       = 303800;
  localparam int K_Z        = 1041219;
  localparam int VMAX       = 1048575;
  localparam int VMIN       = -1048576;

  typedef struct packed {
    logic [15:0] ac1;
    logic [15:0] ac2;
    logic [15:0] ac3;
    logic [15:0] ac4;
    logic [15:0] ac5;
    logic [15:0] ac6;
    logic [15:0] vb1;
    logic [15:0] vb2;
    logic [15:0] mc;
    logic [15:0] md;
  } cal_t;

  // one classified item, front to back
  typedef struct packed {
    logic                     op;
    logic                     zero;
    logic                     sgn;
    logic [MAGA_W-1:0]        mag_a;
    logic [MAGD_W-1:0]        mag_d;
    logic signed [NLIN_W-1:0] nlin;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage
`default_nettype wire

// ===== design/bsc_front.sv =====
`default_nettype none
module bsc_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_opcode,
  input  logic [bsc_pkg::RAW_T_W-1:0]      in_raw_temperature,
  input  logic [bsc_pkg::RAW_P_W-1:0]      in_raw_pressure,
  input  logic signed [bsc_pkg::TIN_W-1:0] in_temperature_in,
  input  bsc_pkg::cal_t                    cal,
  input  bsc_pkg::qstat_t                  qstat,
  output logic                             push,
  output bsc_pkg::job_t                    push_job
);
  import bsc_pkg::*;

  logic adv;
  logic in_acc;

  // stage 1
  logic                s1_v_r, s1_op_r;
  logic [RAW_P_W-1:0]  s1_rp_r;
  logic signed [16:0]  s1_sd_r, s1_utd_r;
  logic signed [16:0]  s1_sd_nxt, s1_utd_nxt;

  // stage 2
  logic                s2_v_r, s2_op_r;
  logic [RAW_P_W-1:0]  s2_rp_r;
  logic [31:0]         s2_sq_r;
  logic signed [32:0]  s2_m2_r, s2_m3_r;
  logic signed [NLIN_W-1:0] s2_nlin_r;
  logic signed [33:0]  sq_nxt;

  // stage 3
  logic                s3_v_r, s3_op_r;
  logic [RAW_P_W-1:0]  s3_rp_r;
  logic signed [47:0]  s3_v1_r, s3_v2_r;
  logic signed [35:0]  s3_tb_r, s3_tc_r;
  logic signed [34:0]  s3_dent_r;
  logic signed [NLIN_W-1:0] s3_nlin_r;

  // stage 4
  logic                s4_v_r, s4_op_r;
  logic signed [57:0]  s4_num_r;
  logic signed [58:0]  s4_den_r;
  logic signed [34:0]  s4_dent_r;
  logic signed [NLIN_W-1:0] s4_nlin_r;
  logic signed [59:0]  num_nxt, den_nxt;
  logic signed [59:0]  v1_t, v2_t;

  // job forming
  logic [16:0] mc_ext, mc_mag;
  logic [34:0] dent_mag;
  logic [57:0] num_mag;
  logic [58:0] den_mag;

  assign adv    = !(s4_v_r && qstat.full);
  assign busy   = !adv;
  assign in_acc = start && adv;
  assign push   = s4_v_r && adv;

  assign s1_sd_nxt  = 17'($signed(in_temperature_in)) - 17'(T_REF);
  assign s1_utd_nxt = $signed({1'b0, in_raw_temperature}) - $signed({1'b0, cal.ac6});

  assign sq_nxt = 34'(s1_sd_r) * 34'(s1_sd_r);

  // constant times 800 as shifts
  assign v1_t = (60'(s3_v1_r) <<< 9) + (60'(s3_v1_r) <<< 8) + (60'(s3_v1_r) <<< 5);
  assign v2_t = (60'(s3_v2_r) <<< 9) + (60'(s3_v2_r) <<< 8) + (60'(s3_v2_r) <<< 5);

  assign num_nxt = (60'($signed({1'b0, s3_rp_r})) <<< 28) - v2_t
                 - (60'(s3_tb_r) <<< 20) - (60'($signed(cal.ac1)) <<< 36);
  assign den_nxt = (60'sd1 <<< 56) + (60'(s3_tc_r) <<< 23) + v1_t;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_acc;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op_r   <= in_opcode;
      s1_rp_r   <= in_raw_pressure;
      s1_sd_r   <= s1_sd_nxt;
      s1_utd_r  <= s1_utd_nxt;

      s2_op_r   <= s1_op_r;
      s2_rp_r   <= s1_rp_r;
      s2_sq_r   <= sq_nxt[31:0];
      s2_m2_r   <= 33'($signed(cal.ac2)) * 33'(s1_sd_r);
      s2_m3_r   <= 33'($signed(cal.ac3)) * 33'(s1_sd_r);
      s2_nlin_r <= 34'($signed({1'b0, cal.ac5})) * 34'(s1_utd_r);

      s3_op_r   <= s2_op_r;
      s3_rp_r   <= s2_rp_r;
      s3_v1_r   <= 48'($signed(cal.vb1)) * $signed({16'b0, s2_sq_r});
      s3_v2_r   <= 48'($signed(cal.vb2)) * $signed({16'b0, s2_sq_r});
      s3_tb_r   <= 36'(s2_m2_r) + (36'(s2_m2_r) <<< 2);
      s3_tc_r   <= 36'(s2_m3_r) + (36'(s2_m3_r) <<< 2);
      s3_dent_r <= 35'(s2_nlin_r) + (35'($signed(cal.md)) <<< 15);
      s3_nlin_r <= s2_nlin_r;

      s4_op_r   <= s3_op_r;
      s4_num_r  <= num_nxt[57:0];
      s4_den_r  <= den_nxt[58:0];
      s4_dent_r <= s3_dent_r;
      s4_nlin_r <= s3_nlin_r;
    end
  end

  // magnitudes and signs for the back end
  assign mc_ext   = {cal.mc[15], cal.mc};
  assign mc_mag   = mc_ext[16] ? (~mc_ext + 17'd1) : mc_ext;
  assign dent_mag = s4_dent_r[34] ? 35'(-s4_dent_r) : 35'(s4_dent_r);
  assign num_mag  = s4_num_r[57] ? 58'(-s4_num_r) : 58'(s4_num_r);
  assign den_mag  = s4_den_r[58] ? 59'(-s4_den_r) : 59'(s4_den_r);

  always_comb begin
    push_job.op   = s4_op_r;
    push_job.nlin = s4_nlin_r;
    if (s4_op_r == OP_TEMP) begin
      push_job.zero  = (s4_dent_r == '0);
      push_job.sgn   = cal.mc[15] ^ s4_dent_r[34];
      push_job.mag_a = MAGA_W'(mc_mag);
      push_job.mag_d = MAGD_W'(dent_mag);
    end else begin
      push_job.zero  = (cal.ac4 == '0) || (s4_den_r == '0);
      push_job.sgn   = s4_num_r[57] ^ s4_den_r[58];
      push_job.mag_a = num_mag[MAGA_W-1:0];
      push_job.mag_d = den_mag[MAGD_W-1:0];
    end
  end

endmodule
`default_nettype wire

// ===== design/bsc_queue.sv =====
`default_nettype none
module bsc_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  bsc_pkg::job_t   push_job,
  input  logic            pop,
  output bsc_pkg::job_t   pop_job,
  output bsc_pkg::qstat_t qstat
);
  import bsc_pkg::*;

  job_t       mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;

  assign qstat.full  = (cnt_r == 2'd2);
  assign qstat.empty = (cnt_r == 2'd0);
  assign pop_job     = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      if (push && !pop)      cnt_r <= cnt_r + 2'd1;
      else if (pop && !push) cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_job;
  end

endmodule
`default_nettype wire

// ===== design/bsc_back.sv =====
`default_nettype none
module bsc_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bsc_pkg::cal_t                       cal,
  input  bsc_pkg::qstat_t                     qstat,
  input  bsc_pkg::job_t                       pop_job,
  output logic                                pop,
  output logic                                out_strobe,
  output logic signed [bsc_pkg::VALUE_W-1:0]  out_value,
  output logic [bsc_pkg::STATUS_W-1:0]        out_status
);
  import bsc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_DSTART, S_DIV, S_MID, S_DIV5, S_POST, S_MAC, S_SUM, S_RND, S_EMIT
  } state_t;

  state_t state_r;

  logic                     op_r, zero_r, sgn_r, pass_r;
  logic [MAGA_W-1:0]        mag_a_r;
  logic [MAGD_W-1:0]        mag_d_r;
  logic signed [NLIN_W-1:0] nlin_r;

  // divider
  logic [DVD_W-1:0]  dvd_r;
  logic [MAGD_W-1:0] dvs_r, rem_r;
  logic [QUO_W-1:0]  lo_r, quo_r, q_res;
  logic              sat_r;
  logic [5:0]        cnt_r;
  logic [MAGD_W:0]   trial;
  logic              ge;

  // temperature scaling: shift by 12, then divide by five in 15-bit chunks
  logic [44:0] d5_w_r;
  logic [2:0]  d5_rem_r;
  logic [17:0] d5_v;
  logic [33:0] d5_p;
  logic [14:0] d5_q;
  logic [17:0] d5_r;
  logic [63:0] thalf;

  // multiply-accumulate
  logic [36:0]  zm_r;
  logic [56:0]  zq_r;
  logic [46:0]  t1_r;
  logic [44:0]  t2_r;
  logic [2:0]   step_r;
  logic         phase_r;
  logic [48:0]  prod_r;
  logic [75:0]  acc_r, acc_nxt, rnd_k;
  logic [28:0]  mul_a;
  logic [19:0]  mul_b;
  logic [6:0]   sh;
  logic         first;

  logic signed [49:0] sum_r;
  logic signed [44:0] val_r;
  logic signed [VALUE_W-1:0] out_value_r;
  logic [STATUS_W-1:0]       out_status_r;
  logic                      out_strobe_r;

  // operand forming
  logic [DVD_W-1:0]   a_ext, k1000, pres_dvd, temp_dvd;
  logic signed [63:0] tsum;
  logic [63:0]        tmag;
  logic [49:0]        smag;
  logic [32:0]        vrnd;

  assign pop        = (state_r == S_IDLE) && !qstat.empty;
  assign out_strobe = out_strobe_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

  assign a_ext    = DVD_W'(mag_a_r);
  assign k1000    = (a_ext << 10) - (a_ext << 4) - (a_ext << 3);
  assign pres_dvd = (k1000 << 36) + DVD_W'(mag_d_r >> 1);
  assign temp_dvd = (DVD_W'(mag_a_r[16:0]) << 41) + DVD_W'(mag_d_r >> 1);

  assign trial = {rem_r, lo_r[QUO_W-1]};
  assign ge    = (trial >= {1'b0, dvs_r});
  assign q_res = sat_r ? {QUO_W{1'b1}} : quo_r;

  assign tsum = sgn_r ? (64'(nlin_r) - $signed({1'b0, q_res}))
                      : (64'(nlin_r) + $signed({1'b0, q_res}));
  assign tmag = tsum[63] ? 64'(-tsum) : 64'(tsum);
  assign smag = sum_r[49] ? 50'(-sum_r) : 50'(sum_r);
  assign vrnd = 33'((smag + 50'd32768) >> 16);

  // one chunk of the divide by five: remainder below five, so the operand stays under 2^18
  assign thalf = tmag + 64'(TEMP_HALF);
  assign d5_v  = {d5_rem_r, d5_w_r[44:30]};
  assign d5_p  = 34'(d5_v) * 34'(RECIP5);
  assign d5_q  = d5_p[32:18];
  assign d5_r  = d5_v - (18'(d5_q) << 2) - 18'(d5_q);

  // partial product schedule
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    sh    = '0;
    first = 1'b0;
    rnd_k = '0;
    unique case (step_r)
      3'd0: begin
        mul_a = 29'(zm_r[36:19]); mul_b = 20'(zm_r[36:19]); sh = 7'd38;
        first = 1'b1; rnd_k = 76'd1 << 15;
      end
      3'd1: begin
        mul_a = 29'(zm_r[36:19]); mul_b = 20'(zm_r[18:0]); sh = 7'd20;
      end
      3'd2: begin
        mul_a = 29'(zm_r[18:0]); mul_b = 20'(zm_r[18:0]);
      end
      3'd3: begin
        mul_a = zq_r[28:0]; mul_b = 20'(K_ZQ);
        first = 1'b1; rnd_k = 76'd1 << 27;
      end
      3'd4: begin
        mul_a = 29'(zq_r[56:29]); mul_b = 20'(K_ZQ); sh = 7'd29;
      end
      3'd5: begin
        mul_a = zm_r[28:0]; mul_b = 20'(K_Z);
        first = 1'b1; rnd_k = 76'd2048;
      end
      3'd6: begin
        mul_a = 29'(zm_r[36:29]); mul_b = 20'(K_Z); sh = 7'd29;
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  assign acc_nxt = (first ? rnd_k : acc_r) + (76'(prod_r) << sh);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (!qstat.empty) begin
            op_r    <= pop_job.op;
            zero_r  <= pop_job.zero;
            sgn_r   <= pop_job.sgn;
            mag_a_r <= pop_job.mag_a;
            mag_d_r <= pop_job.mag_d;
            nlin_r  <= pop_job.nlin;
            state_r <= pop_job.zero ? S_EMIT : S_PREP;
          end
        end
        S_PREP: begin
          pass_r  <= 1'b0;
          dvs_r   <= mag_d_r;
          dvd_r   <= (op_r == OP_PRES) ? pres_dvd : temp_dvd;
          state_r <= S_DSTART;
        end
        S_DSTART: begin
          sat_r   <= (MAGD_W'(dvd_r[DVD_W-1:QUO_W]) >= dvs_r);
          rem_r   <= MAGD_W'(dvd_r[DVD_W-1:QUO_W]);
          lo_r    <= dvd_r[QUO_W-1:0];
          cnt_r   <= 6'(QUO_W - 1);
          state_r <= S_DIV;
        end
        S_DIV: begin
          rem_r <= ge ? MAGD_W'(trial - {1'b0, dvs_r}) : trial[MAGD_W-1:0];
          lo_r  <= lo_r << 1;
          quo_r <= {quo_r[QUO_W-2:0], ge};
          cnt_r <= cnt_r - 6'd1;
          if (cnt_r == 6'd0) state_r <= pass_r ? S_POST : S_MID;
        end
        S_MID: begin
          pass_r <= 1'b1;
          if (op_r == OP_TEMP) begin
            sgn_r    <= tsum[63];
            d5_w_r   <= thalf[56:12];
            d5_rem_r <= '0;
            cnt_r    <= 6'd2;
            state_r  <= S_DIV5;
          end else begin
            dvd_r   <= DVD_W'(q_res) + DVD_W'(cal.ac4 >> 1);
            dvs_r   <= MAGD_W'(cal.ac4);
            state_r <= S_DSTART;
          end
        end
        S_DIV5: begin
          d5_w_r   <= {d5_w_r[29:0], d5_q};
          d5_rem_r <= d5_r[2:0];
          cnt_r    <= cnt_r - 6'd1;
          if (cnt_r == 6'd0) state_r <= S_POST;
        end
        S_POST: begin
          if (op_r == OP_TEMP) begin
            val_r   <= sgn_r ? -$signed({1'b0, d5_w_r[43:0]})
                             : $signed({1'b0, d5_w_r[43:0]});
            state_r <= S_EMIT;
          end else begin
            zm_r    <= (q_res > (QUO_W'(1) << 36)) ? (37'd1 << 36) : q_res[36:0];
            step_r  <= 3'd0;
            phase_r <= 1'b0;
            state_r <= S_MAC;
          end
        end
        S_MAC: begin
          if (!phase_r) begin
            prod_r  <= 49'(mul_a) * 49'(mul_b);
            phase_r <= 1'b1;
          end else begin
            acc_r   <= acc_nxt;
            phase_r <= 1'b0;
            step_r  <= step_r + 3'd1;
            if (step_r == 3'd2) zq_r <= acc_nxt[72:16];
            if (step_r == 3'd4) t1_r <= acc_nxt[74:28];
            if (step_r == 3'd6) begin
              t2_r    <= acc_nxt[56:12];
              state_r <= S_SUM;
            end
          end
        end
        S_SUM: begin
          sum_r   <= $signed(50'(t1_r)) + (sgn_r ? -$signed(50'(t2_r)) : $signed(50'(t2_r)))
                   + 50'sd39667630;
          state_r <= S_RND;
        end
        S_RND: begin
          val_r   <= sum_r[49] ? -$signed({12'b0, vrnd}) : $signed({12'b0, vrnd});
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          out_strobe_r <= 1'b1;
          if (zero_r) begin
            out_value_r  <= '0;
            out_status_r <= ST_ZERO;
          end else if (val_r > 45'(VMAX)) begin
            out_value_r  <= VALUE_W'(VMAX);
            out_status_r <= ST_SAT;
          end else if (val_r < 45'(VMIN)) begin
            out_value_r  <= VALUE_W'(VMIN);
            out_status_r <= ST_SAT;
          end else begin
            out_value_r  <= val_r[VALUE_W-1:0];
            out_status_r <= ST_OK;
          end
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/baro_sensor_compensation.sv =====
`default_nettype none
// a beat passes the front stages and the queue, then the back end, whose run is longer
//   for a pressure beat than for a temperature beat; a zero divisor goes straight to out_strobe
// the back end takes a new beat only after it has emitted the last, since its bit-serial
//   divider is not pipelined; the front takes up to six beats ahead of it
// reset: rst_n low at a clock edge clears the calibration words, the pipeline and the queue
// results cannot be held off: out_strobe is high for exactly one cycle per beat
module baro_sensor_compensation (
  input  logic                                clk,
  input  logic                                rst_n,
  // command side
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_opcode,
  input  logic [bsc_pkg::RAW_T_W-1:0]         in_raw_temperature,
  input  logic [bsc_pkg::RAW_P_W-1:0]         in_raw_pressure,
  input  logic signed [bsc_pkg::TIN_W-1:0]    in_temperature_in,
  // result side
  output logic                                out_strobe,
  output logic signed [bsc_pkg::VALUE_W-1:0]  out_value,
  output logic [bsc_pkg::STATUS_W-1:0]        out_status,
  // calibration write port
  input  logic                                cfg_we,
  input  logic [bsc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bsc_pkg::CFG_W-1:0]           cfg_wdata
);
  import bsc_pkg::*;

  // packed calibration words, as written
  logic [63:0] cal_a_r;
  logic [63:0] cal_b_r;
  logic [31:0] cal_c_r;

  cal_t   cal;
  qstat_t qstat;
  job_t   push_job, pop_job;
  logic   push, pop;

  // writes to an index past the last register are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_a_r <= '0;
      cal_b_r <= '0;
      cal_c_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CAL_A: cal_a_r <= cfg_wdata;
        REG_CAL_B: cal_b_r <= cfg_wdata;
        REG_CAL_C: cal_c_r <= cfg_wdata[31:0];
        default:   cal_c_r <= cal_c_r;
      endcase
    end
  end

  // unpack the ten calibration words
  assign cal.ac1 = cal_a_r[63:48];
  assign cal.ac2 = cal_a_r[47:32];
  assign cal.ac3 = cal_a_r[31:16];
  assign cal.ac4 = cal_a_r[15:0];
  assign cal.ac5 = cal_b_r[63:48];
  assign cal.ac6 = cal_b_r[47:32];
  assign cal.vb1 = cal_b_r[31:16];
  assign cal.vb2 = cal_b_r[15:0];
  assign cal.mc  = cal_c_r[31:16];
  assign cal.md  = cal_c_r[15:0];

  // front: four-stage pipeline forming the pressure numerator and denominator or the
  // temperature divisor, stalls only when the queue is full
  bsc_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_opcode          (in_opcode),
    .in_raw_temperature (in_raw_temperature),
    .in_raw_pressure    (in_raw_pressure),
    .in_temperature_in  (in_temperature_in),
    .cal                (cal),
    .qstat              (qstat),
    .push               (push),
    .push_job           (push_job)
  );

  // two-entry queue between the halves
  bsc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .qstat    (qstat)
  );

  // back: one pass (temperature) or two passes (pressure) through a shared
  // restoring divider, a short divide by five for the temperature scale, and a
  // small multiply-accumulate sequence for the final pressure quadratic
  bsc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cal        (cal),
    .qstat      (qstat),
    .pop_job    (pop_job),
    .pop        (pop),
    .out_strobe (out_strobe),
    .out_value  (out_value),
    .out_status (out_status)
  );

endmodule
`default_nettype wire

// ===== tb/tb_baro_sensor_compensation.sv =====
`timescale 1ns / 1ps
module tb_baro_sensor_compensation;
  import bsc_pkg::*;

  // index 3 is not decoded by the block, writes to it must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  // datasheet-like calibration set, used in the directed plan and as the base for the even random phases
  localparam logic [63:0] CAL_A_TYP = 64'h0198_FFB8_C7D1_7FE5;
  localparam logic [63:0] CAL_B_TYP = 64'h7FF5_5A71_182E_0004;
  localparam logic [63:0] CAL_C_TYP = 64'h0000_0000_DDF9_0B34;

  localparam int PHASES      = 8;
  localparam int PHASE_BEATS = 180;

  typedef struct {
    logic signed [VALUE_W-1:0] value;
    logic [STATUS_W-1:0]       status;
  } reading_t;

  // one line of the directed plan: either a calibration write or a command beat
  typedef struct {
    bit                        is_write;
    logic [CFG_IDX_W-1:0]      idx;
    logic [CFG_W-1:0]          data;
    logic                      op;
    logic [RAW_T_W-1:0]        rt;
    logic [RAW_P_W-1:0]        rp;
    logic signed [TIN_W-1:0]   tin;
    bit                        typed;
    reading_t                  want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_opcode = OP_TEMP;
  logic [RAW_T_W-1:0] in_raw_temperature = '0;
  logic [RAW_P_W-1:0] in_raw_pressure = '0;
  logic signed [TIN_W-1:0] in_temperature_in = '0;
  logic out_strobe;
  logic signed [VALUE_W-1:0] out_value;
  logic [STATUS_W-1:0] out_status;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_CAL_A;
  logic [CFG_W-1:0] cfg_wdata = '0;

  // shadow of the calibration words as the predictor sees them
  logic [63:0] cal_a = '0;
  logic [63:0] cal_b = '0;
  logic [31:0] cal_c = '0;

  reading_t pending_readings[$];
  plan_row_t plan[$];
  int mismatches = 0;
  bit quiet_stretch = 1'b0;

  baro_sensor_compensation dut (
    .clk(clk), .rst_n(rst_n),
    .start(start), .busy(busy),
    .in_opcode(in_opcode), .in_raw_temperature(in_raw_temperature),
    .in_raw_pressure(in_raw_pressure), .in_temperature_in(in_temperature_in),
    .out_strobe(out_strobe), .out_value(out_value), .out_status(out_status),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // round(a*b/c) with ties away from zero, 128-bit product, saturated to +-(2^63-1)
  function automatic longint scaled_div(longint a, longint b, longint c);
    logic [63:0] ua, ub, uc;
    logic [127:0] prod, quo;
    bit neg;
    neg = ((a < 0) != (b < 0)) != (c < 0);
    ua = a;
    ub = b;
    uc = c;
    if (a < 0) ua = -ua;
    if (b < 0) ub = -ub;
    if (c < 0) uc = -uc;
    prod = {64'd0, ua} * {64'd0, ub} + {65'd0, uc[63:1]};
    quo = prod / {64'd0, uc};
    if (quo > 128'h7FFF_FFFF_FFFF_FFFF) quo = 128'h7FFF_FFFF_FFFF_FFFF;
    return neg ? -longint'(quo[63:0]) : longint'(quo[63:0]);
  endfunction

  function automatic reading_t pack_reading(longint v, logic [STATUS_W-1:0] st);
    reading_t r;
    if (st != ST_ZERO) begin
      if (v > VMAX) begin
        v = VMAX;
        st = ST_SAT;
      end
      if (v < VMIN) begin
        v = VMIN;
        st = ST_SAT;
      end
    end
    r.value = v[VALUE_W-1:0];
    r.status = st;
    return r;
  endfunction

  // compensated reading for one command beat under the current calibration
  function automatic reading_t compensate(logic op, logic [RAW_T_W-1:0] rt,
                                          logic [RAW_P_W-1:0] rp,
                                          logic signed [TIN_W-1:0] tin);
    longint ac1, ac2, ac3, ac4, ac5, ac6, vb1, vb2, mc, md;
    longint nlin, den, corr, sd, sq, offs, num, q, z, zq, acc;
    ac1 = longint'($signed(cal_a[63:48]));
    ac2 = longint'($signed(cal_a[47:32]));
    ac3 = longint'($signed(cal_a[31:16]));
    ac4 = longint'(cal_a[15:0]);
    ac5 = longint'(cal_b[63:48]);
    ac6 = longint'(cal_b[47:32]);
    vb1 = longint'($signed(cal_b[31:16]));
    vb2 = longint'($signed(cal_b[15:0]));
    mc  = longint'($signed(cal_c[31:16]));
    md  = longint'($signed(cal_c[15:0]));
    if (op == OP_TEMP) begin
      nlin = ac5 * (longint'(rt) - ac6);
      den = nlin + md * 32768;
      if (den == 0) return pack_reading(0, ST_ZERO);
      corr = scaled_div(mc * (longint'(1) << 41), 1, den);
      return pack_reading(scaled_div(nlin + corr, 1, TEMP_DIV), ST_OK);
    end
    sd = longint'(tin) - T_REF;
    sq = sd * sd;
    offs = 800 * vb2 * sq + 5 * ac2 * sd * (longint'(1) << 20) + ac1 * (longint'(1) << 36);
    num = longint'(rp) * (longint'(1) << 28) - offs;
    den = (longint'(1) << 56) + 5 * ac3 * sd * (longint'(1) << 23) + 800 * vb1 * sq;
    if (ac4 == 0 || den == 0) return pack_reading(0, ST_ZERO);
    q = scaled_div(num, 1000 * (longint'(1) << 36), den);
    z = scaled_div(q, 1, ac4);
    if (z > (longint'(1) << 36)) z = longint'(1) << 36;
    if (z < -(longint'(1) << 36)) z = -(longint'(1) << 36);
    zq = scaled_div(z, z, 65536);
    acc = scaled_div(zq, K_ZQ, longint'(1) << 28) + scaled_div(z, K_Z, 4096) + P_BIAS;
    return pack_reading(scaled_div(acc, 1, 65536), ST_OK);
  endfunction

  // command beat: held until busy is low at a rising edge, then an optional gap
  task automatic issue_beat(logic op, logic [RAW_T_W-1:0] rt, logic [RAW_P_W-1:0] rp,
                            logic signed [TIN_W-1:0] tin, bit typed, reading_t want);
    @(negedge clk);
    start = 1'b1;
    in_opcode = op;
    in_raw_temperature = rt;
    in_raw_pressure = rp;
    in_temperature_in = tin;
    do @(posedge clk); while (busy);
    pending_readings.push_back(typed ? want : compensate(op, rt, rp, tin));
    if (!quiet_stretch && $urandom_range(99) < 31) begin
      @(negedge clk);
      start = 1'b0;
      repeat ($urandom_range(7)) @(negedge clk);
    end
  endtask

  // calibration writes only once the block has drained
  task automatic write_cal(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    start = 1'b0;
    while (pending_readings.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_CAL_A: cal_a = data;
      REG_CAL_B: cal_b = data;
      REG_CAL_C: cal_c = data[31:0];
      default: ;
    endcase
  endtask

  function automatic void plan_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    plan_row_t r;
    r = '{default: '0};
    r.is_write = 1'b1;
    r.idx = idx;
    r.data = data;
    plan.push_back(r);
  endfunction

  function automatic void plan_beat(logic op, logic [RAW_T_W-1:0] rt,
                                    logic [RAW_P_W-1:0] rp, logic signed [TIN_W-1:0] tin,
                                    bit typed = 1'b0, logic signed [VALUE_W-1:0] v = '0,
                                    logic [STATUS_W-1:0] st = ST_OK);
    plan_row_t r;
    r = '{default: '0};
    r.op = op;
    r.rt = rt;
    r.rp = rp;
    r.tin = tin;
    r.typed = typed;
    r.want.value = v;
    r.want.status = st;
    plan.push_back(r);
  endfunction

  // result checker: every strobe must match the oldest outstanding reading
  always @(posedge clk) begin
    reading_t w;
    if (rst_n && out_strobe) begin
      if (pending_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: value %0d status %0d", out_value, out_status);
      end else begin
        w = pending_readings.pop_front();
        if (w.value !== out_value || w.status !== out_status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: want value %0d status %0d, got value %0d status %0d",
                     w.value, w.status, out_value, out_status);
        end
      end
    end
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    logic [63:0] wa, wb, wc;
    logic op;
    logic [RAW_P_W-1:0] rp;
    logic signed [TIN_W-1:0] tin;
    reading_t none;
    none = '{default: '0};

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // calibration all zero after reset: every beat hits a zero divisor
    plan_beat(OP_TEMP, 16'h0000, '0, '0, 1'b1, '0, ST_ZERO);
    plan_beat(OP_PRES, '0, 24'hFFFFFF, 16'sh7FFF, 1'b1, '0, ST_ZERO);
    // typical calibration, field extremes and the reference point 25 degC
    plan_write(REG_CAL_A, CAL_A_TYP);
    plan_write(REG_CAL_B, CAL_B_TYP);
    plan_write(REG_CAL_C, CAL_C_TYP);
    plan_beat(OP_TEMP, 16'h0000, '0, '0);
    plan_beat(OP_TEMP, 16'hFFFF, '0, '0);
    plan_beat(OP_TEMP, 16'd27898, '0, '0);
    plan_beat(OP_PRES, '0, 24'h000000, 16'sd6400);
    plan_beat(OP_PRES, '0, 24'hFFFFFF, 16'sd6400);
    plan_beat(OP_PRES, '0, 24'h5D2300, -16'sd32768);
    plan_beat(OP_PRES, '0, 24'h5D2300, 16'sd32767);
    plan_beat(OP_PRES, '0, 24'h5D2300, 16'sd5940);
    // writes to the undecoded index change nothing
    plan_write(REG_SPARE, 64'hFFFF_FFFF_FFFF_FFFF);
    plan_beat(OP_PRES, '0, 24'h5D2300, 16'sd5940);
    // temperature divisor forced to zero: ac5 = 0 and md = 0
    plan_write(REG_CAL_B, 64'h0000_5A71_182E_0004);
    plan_write(REG_CAL_C, 64'hFFFF_FFFF_DDF9_0000);
    plan_beat(OP_TEMP, 16'd27898, '0, '0, 1'b1, '0, ST_ZERO);
    // ac4 = 0 gives a zero divisor for pressure
    plan_write(REG_CAL_A, 64'h0198_FFB8_C7D1_0000);
    plan_beat(OP_PRES, '0, 24'h5D2300, 16'sd5940, 1'b1, '0, ST_ZERO);
    // every calibration bit high
    plan_write(REG_CAL_A, 64'hFFFF_FFFF_FFFF_FFFF);
    plan_write(REG_CAL_B, 64'hFFFF_FFFF_FFFF_FFFF);
    plan_write(REG_CAL_C, 64'hFFFF_FFFF_FFFF_FFFF);
    plan_beat(OP_TEMP, 16'hFFFF, '0, '0);
    plan_beat(OP_TEMP, 16'h0000, '0, '0);
    plan_beat(OP_PRES, '0, 24'hFFFFFF, -16'sd32768);
    plan_beat(OP_PRES, '0, 24'h000000, 16'sd32767);

    foreach (plan[i]) begin
      if (plan[i].is_write) write_cal(plan[i].idx, plan[i].data);
      else issue_beat(plan[i].op, plan[i].rt, plan[i].rp, plan[i].tin,
                      plan[i].typed, plan[i].want);
    end

    // random phases, each under its own calibration
    for (int ph = 0; ph < PHASES; ph++) begin
      wa = {$urandom, $urandom};
      wb = {$urandom, $urandom};
      wc = {$urandom, $urandom};
      if (ph % 2 == 0) begin
        // typical set with low bits disturbed, keeps results mostly in range
        wa = CAL_A_TYP ^ (wa & 64'h00FF_00FF_03FF_03FF);
        wb = CAL_B_TYP ^ (wb & 64'h03FF_03FF_00FF_000F);
        wc = CAL_C_TYP ^ (wc & 64'hFFFF_FFFF_03FF_00FF);
      end
      write_cal(REG_CAL_A, wa);
      write_cal(REG_CAL_B, wb);
      write_cal(REG_CAL_C, wc);
      quiet_stretch = (ph == 3);
      for (int n = 0; n < PHASE_BEATS; n++) begin
        op = 1'($urandom_range(1));
        if ($urandom_range(3) == 0) rp = 24'($urandom);
        else rp = 24'($urandom_range(24'h6A0000, 24'h480000));
        if ($urandom_range(3) == 0) tin = 16'($urandom);
        else tin = 16'($urandom_range(12800, 0));
        issue_beat(op, 16'($urandom), rp, tin, 1'b0, none);
      end
    end
    quiet_stretch = 1'b0;

    @(negedge clk);
    start = 1'b0;
    while (pending_readings.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/bsc_pkg.sv
design/bsc_front.sv
design/bsc_queue.sv
design/bsc_back.sv
design/baro_sensor_compensation.sv
tb/tb_baro_sensor_compensation.sv
